[design/bse_pkg.sv]
// shared types, constants and control structs for the binary search engine
package bse_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int BOUND_W     = COUNT_W + 1;
    localparam int DATA_W      = 32;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic                      command;
        logic [7:0]                write_index;
        logic signed [DATA_W-1:0]  entry_value;
        logic signed [DATA_W-1:0]  search_key;
    } bse_req_t;

    typedef struct packed {
        logic       found;
        logic [7:0] position;
    } bse_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic wr_entry;
        logic load_search;
        logic rd_probe;
        logic step_down;
        logic step_up;
        logic set_found;
        logic load_out;
    } bse_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic bounds_ok;
        logic key_lt;
        logic key_eq;
        logic out_free;
    } bse_stat_t;

endpackage

[design/binary_search_engine.sv]
// top level of the binary search engine: controller plus datapath
//
//  channel   direction  handshake              word
//  req       in         req_valid/req_ready    bse_req_t (write entry or search key)
//  rsp       out        rsp_valid/rsp_ready    bse_rsp_t (found, position)
//  cfg       in         cfg_wr_en              entry_count, 9 bits
//
// a write word goes straight into the table from idle; a search runs one probe
// per check/compare pass (at most nine probes over 256 entries), each made of
// the registered table read followed by the compare, with a last bounds check
// on a miss
// reset clears the controller, entry_count and the result valid; the table
// itself is not cleared and holds garbage until written
// a finished result waits in the output register; a further search only
// stalls at its end if the previous result has not yet been taken
module binary_search_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [8:0]         cfg_wr_data,
    input  logic               req_valid,
    output logic               req_ready,
    input  bse_pkg::bse_req_t  req_word,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output bse_pkg::bse_rsp_t  rsp_word
);
    import bse_pkg::*;

    // command and status between the two halves
    bse_cmd_t  cmd;
    bse_stat_t stat;

    // sequencing: idle, probe issue, compare, result hand-off
    bse_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_command (req_word.command),
        .stat        (stat),
        .cmd         (cmd)
    );

    // table memory, search bounds, key compare and result register
    bse_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_word    (req_word),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_word    (rsp_word),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

[design/bse_ctrl.sv]
// controller state machine for the binary search engine
module bse_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic               req_command,
    input  bse_pkg::bse_stat_t stat,
    output bse_pkg::bse_cmd_t  cmd
);
    import bse_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_CHECK   = 2'd1;
    localparam logic [1:0] ST_COMPARE = 2'd2;
    localparam logic [1:0] ST_FINISH  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_command == CMD_SEARCH)
                    begin
                        cmd.load_search = 1'b1;
                        state_next      = ST_CHECK;
                    end
                    else
                    begin
                        cmd.wr_entry = 1'b1;
                    end
                end
            end
            ST_CHECK:
            begin
                if (stat.bounds_ok)
                begin
                    cmd.rd_probe = 1'b1;
                    state_next   = ST_COMPARE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_COMPARE:
            begin
                if (stat.key_eq)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = ST_FINISH;
                end
                else if (stat.key_lt)
                begin
                    cmd.step_down = 1'b1;
                    state_next    = ST_CHECK;
                end
                else
                begin
                    cmd.step_up = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[design/bse_dp.sv]
// datapath for the binary search engine: table memory, bounds, compare, result word
module bse_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [8:0]          cfg_wr_data,
    input  bse_pkg::bse_req_t   req_word,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output bse_pkg::bse_rsp_t   rsp_word,
    input  bse_pkg::bse_cmd_t   cmd,
    output bse_pkg::bse_stat_t  stat
);
    import bse_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(TABLE_DEPTH);

    logic signed [DATA_W-1:0]  mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0]  rd_data_reg;
    logic signed [DATA_W-1:0]  key_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic signed [BOUND_W-1:0] lo_reg;
    logic signed [BOUND_W-1:0] hi_reg;
    logic [ADDR_W-1:0]         mid_reg;
    logic                      found_reg;
    logic                      rsp_valid_reg;
    bse_rsp_t                  rsp_word_reg;

    logic [COUNT_W-1:0]        count_sat;
    logic signed [BOUND_W-1:0] bound_sum;
    logic [ADDR_W-1:0]         mid;
    logic signed [BOUND_W-1:0] mid_ext;

    assign count_sat = (count_reg > COUNT_MAX) ? COUNT_MAX : count_reg;
    assign bound_sum = lo_reg + hi_reg;
    // both bounds are non-negative whenever a probe is issued
    assign mid       = bound_sum[ADDR_W:1];
    assign mid_ext   = $signed({{(BOUND_W-ADDR_W){1'b0}}, mid_reg});

    assign stat.bounds_ok = (lo_reg <= hi_reg);
    assign stat.key_lt    = (key_reg < rd_data_reg);
    assign stat.key_eq    = (key_reg == rd_data_reg);
    assign stat.out_free  = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_entry)
            mem[req_word.write_index[ADDR_W-1:0]] <= req_word.entry_value;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_probe)
            rd_data_reg <= mem[mid];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_wr_en)
            count_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_search)
        begin
            key_reg   <= req_word.search_key;
            lo_reg    <= '0;
            hi_reg    <= $signed({1'b0, count_sat}) - BOUND_W'(1);
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rd_probe)
                mid_reg <= mid;
            if (cmd.step_down)
                hi_reg <= mid_ext - BOUND_W'(1);
            if (cmd.step_up)
                lo_reg <= mid_ext + BOUND_W'(1);
            if (cmd.set_found)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.load_out)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rsp_word_reg.found    <= found_reg;
            rsp_word_reg.position <= found_reg ? 8'(mid_reg) : 8'd0;
        end
    end

endmodule

[tb/sv/tb_binary_search_engine.sv]
// self-checking testbench for the binary search engine: table writes, searches, entry_count
`timescale 1ns / 1ps

module tb_binary_search_engine;

    import bse_pkg::*;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // block ports, all known from time zero
    logic       cfg_wr_en   = 1'b0;
    logic [8:0] cfg_wr_data = '0;
    logic       req_valid   = 1'b0;
    logic       req_ready;
    bse_req_t   req_word    = '0;
    logic       rsp_valid;
    logic       rsp_ready   = 1'b0;
    bse_rsp_t   rsp_word;

    binary_search_engine dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_word    (req_word),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_word    (rsp_word)
    );

    // words waiting to be offered, and search results still owed by the block
    bse_req_t word_backlog [$];
    bse_rsp_t expected_hits [$];

    // predictor state: the table as the block should hold it and the live entry_count
    logic signed [DATA_W-1:0] shadow_table [TABLE_DEPTH];
    logic [8:0]               shadow_count = '0;

    // what the table will hold once every queued write has gone in; used to aim search keys
    logic signed [DATA_W-1:0] plan_table [TABLE_DEPTH];

    int mismatch_count = 0;
    int words_planned  = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    // long receiver hold-off: asked for by the stimulus, taken up and counted down by the monitor
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left  = 0;

    // classic binary search over the first entry_count entries, floored midpoint,
    // entry_count saturating at the table depth
    function automatic bse_rsp_t search_table(logic signed [DATA_W-1:0] key);
        bse_rsp_t hit;
        int       lo;
        int       hi;
        int       mid;
        hit = '0;
        lo  = 0;
        hi  = ((shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count)) - 1;
        while (lo <= hi && !hit.found)
        begin
            mid = (lo + hi) / 2;
            if (key < shadow_table[mid])
            begin
                hi = mid - 1;
            end
            else if (key > shadow_table[mid])
            begin
                lo = mid + 1;
            end
            else
            begin
                hit.found    = 1'b1;
                hit.position = mid[7:0];
            end
        end
        return hit;
    endfunction

    // effect of one accepted word on the predictor
    task automatic take_word(bse_req_t w);
        if (w.command == CMD_WRITE)
        begin
            shadow_table[w.write_index] = w.entry_value;
        end
        else
        begin
            expected_hits.push_back(search_table(w.search_key));
        end
    endtask

    // driver: offers the oldest pending word, holds it steady until taken,
    // and idles at random between words
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                take_word(word_backlog.pop_front());
            end
            // a word still on offer keeps valid and payload as they are
            if (!(req_valid && !req_ready))
            begin
                if (word_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req_word  <= word_backlog[0];
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word against the oldest prediction, stalls at random,
    // and runs the long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result word with nothing expected: found %0b position %0d",
                             $time, rsp_word.found, rsp_word.position);
                end
                else
                begin
                    bse_rsp_t want;
                    want = expected_hits.pop_front();
                    if (rsp_word.found !== want.found)
                    begin
                        mismatch_count++;
                        $display("%0t: found mismatch: expected %0b actual %0b",
                                 $time, want.found, rsp_word.found);
                    end
                    if (rsp_word.position !== want.position)
                    begin
                        mismatch_count++;
                        $display("%0t: position mismatch: expected %0d actual %0d",
                                 $time, want.position, rsp_word.position);
                    end
                end
            end
            if (hold_taken != hold_asked)
            begin
                hold_left  = 400;
                hold_taken = hold_asked;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // queue a table write; the unused key field carries noise
    task automatic push_write(logic [7:0] idx, logic signed [DATA_W-1:0] val);
        bse_req_t w;
        w.command     = CMD_WRITE;
        w.write_index = idx;
        w.entry_value = val;
        w.search_key  = $urandom;
        word_backlog.push_back(w);
        plan_table[idx] = val;
        words_planned++;
    endtask

    // queue a search; index and value fields carry noise
    task automatic push_search(logic signed [DATA_W-1:0] key);
        bse_req_t w;
        w.command     = CMD_SEARCH;
        w.write_index = 8'($urandom);
        w.entry_value = $urandom;
        w.search_key  = key;
        word_backlog.push_back(w);
        words_planned++;
    endtask

    // key aimed at the searched window: hits, near misses, extremes or anything
    function automatic logic signed [DATA_W-1:0] aim_key();
        int pick;
        int span;
        span = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
        pick = $urandom_range(0, 9);
        if (span > 0 && pick < 5)
        begin
            return plan_table[$urandom_range(0, span - 1)];
        end
        else if (span > 0 && pick == 5)
        begin
            return plan_table[$urandom_range(0, span - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        end
        else if (pick == 6)
        begin
            return 32'sh8000_0000;
        end
        else if (pick == 7)
        begin
            return 32'sh7fff_ffff;
        end
        return $urandom;
    endfunction

    // non-decreasing run of values from 'first' into entries 0 .. n-1, steps up to 'stride'
    task automatic fill_sorted(int n, longint first, int stride);
        longint v;
        v = first;
        for (int i = 0; i < n; i++)
        begin
            push_write(i[7:0], v[31:0]);
            v = v + $urandom_range(0, stride);
            if (v > 64'sd2147483647)
            begin
                v = 64'sd2147483647;
            end
        end
    endtask

    // wait until the block has nothing left to do
    task automatic wait_drained();
        while (word_backlog.size() != 0 || req_valid || expected_hits.size() != 0)
        begin
            @(negedge clk);
        end
        // margin for a search still in flight
        repeat (24) @(negedge clk);
    endtask

    // entry_count write, only while the block is idle
    task automatic set_count(logic [8:0] value);
        wait_drained();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_count = value;
        @(negedge clk);
    endtask

    // idling follows the progress of the run: sender light then heavy, then none
    task automatic pick_idling();
        if (words_planned < 420)
        begin
            send_idle_pct = 14;
            recv_idle_pct = 47;
        end
        else if (words_planned < 840)
        begin
            send_idle_pct = 47;
            recv_idle_pct = 14;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // one random phase: pick a table shape and count, then searches mixed with writes
    task automatic random_phase();
        int kind;
        int n;
        int cnt;
        int hits;
        kind = $urandom_range(0, 9);
        n    = $urandom_range(1, 24);
        cnt  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n;
        if (kind == 7)
        begin
            // wide window over whatever the table holds, saturating counts too
            cnt = $urandom_range(0, 2) == 0 ? $urandom_range(257, 511) : $urandom_range(25, 256);
        end
        else if (kind == 9)
        begin
            cnt = $urandom_range(0, 1);
        end
        set_count(cnt[8:0]);
        pick_idling();
        if (kind <= 5)
        begin
            // duplicate-rich runs for small strides, sparse ones for large
            fill_sorted(n, longint'($signed($urandom)) >>> $urandom_range(0, 8),
                        $urandom_range(0, 1) ? 3 : 32'h0100_0000);
        end
        else if (kind == 6)
        begin
            // unsorted table: the probe path can miss keys that are present
            for (int i = 0; i < n; i++)
            begin
                push_write(i[7:0], $urandom);
            end
        end
        hits = $urandom_range(8, 30);
        for (int i = 0; i < hits; i++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                if (kind == 8 && cnt > 0)
                begin
                    // rewrite inside the window between searches
                    push_write(8'($urandom_range(0, cnt - 1)), $urandom);
                end
                else
                begin
                    push_write(8'($urandom_range(0, 255)), $urandom);
                end
            end
            push_search(aim_key());
        end
    endtask

    // stimulus and end of run
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle_pct = 14;
        recv_idle_pct = 47;

        // directed: empty window straight after reset, then extremes in the first entries
        push_search(32'sd0);
        push_search(32'sh8000_0000);
        push_write(8'd0, 32'sh8000_0000);
        push_write(8'd1, -32'sd1);
        push_write(8'd2, 32'sd0);
        push_write(8'd3, 32'sh7fff_ffff);

        // four sorted entries: every position, and misses between entries
        set_count(9'd4);
        push_search(32'sh8000_0000);
        push_search(-32'sd1);
        push_search(32'sd0);
        push_search(32'sh7fff_ffff);
        push_search(32'sh8000_0001);
        push_search(-32'sd2);
        push_search(32'sd1);
        push_search(32'sh7fff_fffe);

        // single entry, and an explicit empty window
        set_count(9'd1);
        push_search(32'sh8000_0000);
        push_search(32'sd5);
        set_count(9'd0);
        push_search(32'sh7fff_ffff);

        // whole table sorted across the full range; afterwards every entry is written
        set_count(9'd256);
        fill_sorted(TABLE_DEPTH, -64'sd2147483648, 32'h0200_0000);
        for (int i = 0; i < 40; i++)
        begin
            push_search(aim_key());
        end
        // counts above the depth saturate
        set_count(9'd511);
        for (int i = 0; i < 20; i++)
        begin
            push_search(aim_key());
        end
        set_count(9'd257);
        for (int i = 0; i < 10; i++)
        begin
            push_search(aim_key());
        end

        while (words_planned < 1250)
        begin
            random_phase();
            if (words_planned >= 840 && hold_asked == hold_taken && hold_left == 0
                && (hold_asked == 0 || $urandom_range(0, 2) == 0))
            begin
                // receiver blocks for a long stretch while searches keep coming,
                // so the result register fills and the input stalls
                hold_asked++;
                for (int i = 0; i < 30; i++)
                begin
                    push_search(aim_key());
                end
            end
        end

        wait_drained();
        repeat (40) @(negedge clk);
        if (mismatch_count == 0 && expected_hits.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog well beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
design/bse_pkg.sv
design/bse_ctrl.sv
design/bse_dp.sv
design/binary_search_engine.sv
tb/sv/tb_binary_search_engine.sv
